/* hdl/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranging block.
// Used by the front, back and top-level modules; depends on nothing else.
package uer_pkg;

   localparam int CFG_BITS     = 16;
   localparam int DIST10_BITS  = 20;
   localparam int COUNT_BITS   = 32;
   localparam int DIST_BITS    = 16;

   localparam logic [CFG_BITS-1:0] TRIGGER_PERIOD_RESET = 16'd500;
   localparam logic [CFG_BITS-1:0] TIMEOUT_RESET        = 16'd50;
   localparam logic [CFG_BITS-1:0] MIN_ECHO_RESET       = 16'd100;
   localparam logic [CFG_BITS-1:0] MAX_ECHO_RESET       = 16'd30000;
   localparam logic [CFG_BITS-1:0] MAX_DISTANCE_RESET   = 16'd50000;
   localparam logic [DIST10_BITS-1:0] MAX_DISTANCE_X10_RESET = 20'd500000;

   // Ten times the shortest accepted distance of ten hundredths.
   localparam logic [7:0] MIN_SCALED = 8'd100;

   // Division by ten as multiplication by ceil(2^23 / 10); exact below 2^20.
   localparam int                  DIV_SHIFT  = 23;
   localparam int                  PROD_BITS  = 40;
   localparam logic [DIST10_BITS-1:0] RECIP_TEN = 20'd838861;

   typedef enum logic {
      OP_TICK    = 1'b0,
      OP_CAPTURE = 1'b1
   } op_type;

   typedef enum logic {
      KIND_PERIOD  = 1'b0,
      KIND_CAPTURE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK             = 3'd0,
      STATUS_EDGE_ORDER     = 3'd1,
      STATUS_WIDTH_RANGE    = 3'd2,
      STATUS_DISTANCE_RANGE = 3'd3,
      STATUS_TIMEOUT        = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_TRIGGER_PERIOD = 3'd0,
      CSR_TIMEOUT        = 3'd1,
      CSR_MIN_ECHO       = 3'd2,
      CSR_MAX_ECHO       = 3'd3,
      CSR_MAX_DISTANCE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0]    trigger_period_ms;
      logic [CFG_BITS-1:0]    timeout_ms;
      logic [CFG_BITS-1:0]    min_echo_us;
      logic [CFG_BITS-1:0]    max_echo_us;
      logic [DIST10_BITS-1:0] max_distance_x10;
   } cfg_type;

   typedef struct packed {
      kind_type kind;
      logic     trigger;
      logic     skipped;
      logic     timeout;
   } ctl_type;

   typedef struct packed {
      kind_type              event_kind;
      logic                  trigger;
      logic                  skipped;
      status_type            status;
      logic [DIST_BITS-1:0]  distance_hcm;
      logic [COUNT_BITS-1:0] total_measurements;
      logic [COUNT_BITS-1:0] total_errors;
   } rsp_type;

   function automatic logic [CFG_BITS-1:0] sat_inc16(input logic [CFG_BITS-1:0] v);
      logic [CFG_BITS-1:0] r;
      r = (v == '1) ? v : v + 1'b1;
      return r;
   endfunction

endpackage

/* hdl/ultrasonic_echo_ranging.sv */
// Top level of the ultrasonic echo ranging block: register file, front end,
// request queue, back-end pipeline and result queue. Uses uer_pkg and all uer_ modules.
//
// The block takes one request per clock while the request queue has room and
// returns at most one result per request, in order. The front end writes the
// request queue at the accepting edge. The four back-end stages follow in order:
// edge order and width, width limits and scaling by 17, the distance check
// with the multiply by the reciprocal of ten, and the stage whose status and
// counters are committed as it leaves. From that last stage the result goes
// into the result queue, whose head drives the result ports. Millisecond ticks
// and echo captures are both handled in the front end, so the sustained rate
// is one request per cycle whenever results are popped as fast as they appear.
// While the result queue is full the back end stalls once its last stage holds
// a result, and the request queue fills until req_full rises.
module ultrasonic_echo_ranging #(
   parameter int TIMER_BITS  = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_operation,
   input  logic [31:0] req_rise_time,
   input  logic [31:0] req_fall_time,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_event_kind,
   output logic        rsp_trigger,
   output logic        rsp_skipped,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_distance_hcm,
   output logic [31:0] rsp_total_measurements,
   output logic [31:0] rsp_total_errors,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import uer_pkg::*;

   localparam int MID_BITS = $bits(ctl_type) + 2 * TIMER_BITS;

   cfg_type                cfg_ff;
   logic                   accept;
   logic                   enq_valid;
   ctl_type                enq_ctl;
   logic [TIMER_BITS-1:0]  enq_rise, enq_fall;
   logic                   mid_empty, mid_pop;
   logic [MID_BITS-1:0]    mid_rdata;
   ctl_type                head_ctl;
   logic [TIMER_BITS-1:0]  head_rise, head_fall;
   logic                   out_full, out_push;
   rsp_type                out_entry, rsp_entry;

   assign accept = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_period_ms <= TRIGGER_PERIOD_RESET;
         cfg_ff.timeout_ms        <= TIMEOUT_RESET;
         cfg_ff.min_echo_us       <= MIN_ECHO_RESET;
         cfg_ff.max_echo_us       <= MAX_ECHO_RESET;
         cfg_ff.max_distance_x10  <= MAX_DISTANCE_X10_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRIGGER_PERIOD: cfg_ff.trigger_period_ms <= csr_write_data;
            CSR_TIMEOUT:        cfg_ff.timeout_ms        <= csr_write_data;
            CSR_MIN_ECHO:       cfg_ff.min_echo_us       <= csr_write_data;
            CSR_MAX_ECHO:       cfg_ff.max_echo_us       <= csr_write_data;
            CSR_MAX_DISTANCE: begin
               cfg_ff.max_distance_x10 <= (DIST10_BITS'(csr_write_data) << 3) +
                                          (DIST10_BITS'(csr_write_data) << 1);
            end
            default: begin
            end
         endcase
      end
   end

   uer_front #(
      .TIMER_BITS(TIMER_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .accept        (accept),
      .req_operation (req_operation),
      .req_rise_time (req_rise_time),
      .req_fall_time (req_fall_time),
      .enq_valid     (enq_valid),
      .enq_ctl       (enq_ctl),
      .enq_rise      (enq_rise),
      .enq_fall      (enq_fall)
   );

   uer_fifo #(
      .WIDTH(MID_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (enq_valid),
      .wdata ({enq_ctl, enq_rise, enq_fall}),
      .full  (req_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   assign {head_ctl, head_rise, head_fall} = mid_rdata;

   uer_back #(
      .TIMER_BITS(TIMER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (!mid_empty),
      .head_ctl   (head_ctl),
      .head_rise  (head_rise),
      .head_fall  (head_fall),
      .head_pop   (mid_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_entry  (out_entry)
   );

   uer_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_entry),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_entry),
      .empty (rsp_empty)
   );

   assign rsp_event_kind         = rsp_entry.event_kind;
   assign rsp_trigger            = rsp_entry.trigger;
   assign rsp_skipped            = rsp_entry.skipped;
   assign rsp_status             = rsp_entry.status;
   assign rsp_distance_hcm       = rsp_entry.distance_hcm;
   assign rsp_total_measurements = rsp_entry.total_measurements;
   assign rsp_total_errors       = rsp_entry.total_errors;
endmodule

/* hdl/uer_fifo.sv */
// Small synchronous FIFO built from flip-flops, used for the request and result queues.
// Generic; depends on nothing. DEPTH must be a power of two, at least two.
module uer_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end
endmodule

/* hdl/uer_front.sv */
// Front end: tracks the period counter, busy flag and measurement age for each request.
// Uses uer_pkg; feeds classified events to the queue in front of uer_back.
module uer_front #(
   parameter int TIMER_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  uer_pkg::cfg_type        cfg,
   input  logic                    accept,
   input  logic                    req_operation,
   input  logic [31:0]             req_rise_time,
   input  logic [31:0]             req_fall_time,
   output logic                    enq_valid,
   output uer_pkg::ctl_type        enq_ctl,
   output logic [TIMER_BITS-1:0]   enq_rise,
   output logic [TIMER_BITS-1:0]   enq_fall
);
   import uer_pkg::*;

   logic                busy_ff, busy_in;
   logic [CFG_BITS-1:0] period_ff, period_in;
   logic [CFG_BITS-1:0] age_ff, age_in;

   assign enq_rise = req_rise_time[TIMER_BITS-1:0];
   assign enq_fall = req_fall_time[TIMER_BITS-1:0];

   always_comb begin
      busy_in   = busy_ff;
      period_in = period_ff;
      age_in    = age_ff;
      enq_valid = 1'b0;
      enq_ctl   = '{kind: KIND_PERIOD, trigger: 1'b0, skipped: 1'b0, timeout: 1'b0};
      if (accept) begin
         if (op_type'(req_operation) == OP_TICK) begin
            period_in = sat_inc16(period_ff);
            if (busy_ff) begin
               age_in = sat_inc16(age_ff);
            end
            if (period_in >= cfg.trigger_period_ms) begin
               period_in = '0;
               enq_valid = 1'b1;
               if (busy_ff) begin
                  enq_ctl.skipped = 1'b1;
               end else begin
                  busy_in         = 1'b1;
                  age_in          = '0;
                  enq_ctl.trigger = 1'b1;
               end
               if (busy_in && (age_in > cfg.timeout_ms)) begin
                  enq_ctl.timeout = 1'b1;
                  busy_in         = 1'b0;
               end
            end
         end else if (busy_ff) begin
            busy_in      = 1'b0;
            enq_valid    = 1'b1;
            enq_ctl.kind = KIND_CAPTURE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         period_ff <= '0;
         age_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         period_ff <= period_in;
         age_ff    <= age_in;
      end
   end
endmodule

/* hdl/uer_back.sv */
// Back end: four-stage pipeline that checks echo captures, scales the distance
// and keeps the status and counters. Uses uer_pkg; drains the front queue.
module uer_back #(
   parameter int TIMER_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  uer_pkg::cfg_type        cfg,
   input  logic                    head_valid,
   input  uer_pkg::ctl_type        head_ctl,
   input  logic [TIMER_BITS-1:0]   head_rise,
   input  logic [TIMER_BITS-1:0]   head_fall,
   output logic                    head_pop,
   input  logic                    out_full,
   output logic                    out_push,
   output uer_pkg::rsp_type        out_entry
);
   import uer_pkg::*;

   localparam int SCALED_BITS = TIMER_BITS + 5;

   logic advance;

   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   ctl_type                 s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic                    s1_edge_ff, s2_edge_ff;
   logic [TIMER_BITS-1:0]   s1_width_ff;
   logic                    s2_range_ff;
   logic [SCALED_BITS-1:0]  s2_scaled_ff, s2_scaled_in;
   status_type              s3_status_ff, s3_status_in, s4_status_ff;
   logic [PROD_BITS-1:0]    s3_prod_ff, s3_prod_in;
   logic [DIST_BITS-1:0]    s4_dist_ff;

   status_type              last_status_ff, last_status_in;
   logic [DIST_BITS-1:0]    last_dist_ff, last_dist_in;
   logic [COUNT_BITS-1:0]   accepted_ff, accepted_in;
   logic [COUNT_BITS-1:0]   rejected_ff, rejected_in;

   assign advance  = !s4_valid_ff || !out_full;
   assign head_pop = advance && head_valid;
   assign out_push = s4_valid_ff && !out_full;

   assign s2_scaled_in = (SCALED_BITS'(s1_width_ff) << 4) + SCALED_BITS'(s1_width_ff);

   always_comb begin
      if (s2_edge_ff) begin
         s3_status_in = STATUS_EDGE_ORDER;
      end else if (s2_range_ff) begin
         s3_status_in = STATUS_WIDTH_RANGE;
      end else if ((s2_scaled_ff < SCALED_BITS'(MIN_SCALED)) ||
                   (s2_scaled_ff > SCALED_BITS'(cfg.max_distance_x10))) begin
         s3_status_in = STATUS_DISTANCE_RANGE;
      end else begin
         s3_status_in = STATUS_OK;
      end
      s3_prod_in = PROD_BITS'(s2_scaled_ff[DIST10_BITS-1:0]) * PROD_BITS'(RECIP_TEN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= head_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ctl_ff    <= head_ctl;
         s1_edge_ff   <= (head_fall <= head_rise);
         s1_width_ff  <= head_fall - head_rise;
         s2_ctl_ff    <= s1_ctl_ff;
         s2_edge_ff   <= s1_edge_ff;
         s2_range_ff  <= (s1_width_ff < TIMER_BITS'(cfg.min_echo_us)) ||
                         (s1_width_ff > TIMER_BITS'(cfg.max_echo_us));
         s2_scaled_ff <= s2_scaled_in;
         s3_ctl_ff    <= s2_ctl_ff;
         s3_status_ff <= s3_status_in;
         s3_prod_ff   <= s3_prod_in;
         s4_ctl_ff    <= s3_ctl_ff;
         s4_status_ff <= s3_status_ff;
         s4_dist_ff   <= s3_prod_ff[DIV_SHIFT +: DIST_BITS];
      end
   end

   always_comb begin
      last_status_in = last_status_ff;
      last_dist_in   = last_dist_ff;
      accepted_in    = accepted_ff;
      rejected_in    = rejected_ff;
      if (s4_ctl_ff.kind == KIND_CAPTURE) begin
         accepted_in    = accepted_ff + 1'b1;
         last_status_in = s4_status_ff;
         if (s4_status_ff == STATUS_OK) begin
            last_dist_in = s4_dist_ff;
         end else begin
            rejected_in = rejected_ff + 1'b1;
         end
      end else if (s4_ctl_ff.timeout) begin
         last_status_in = STATUS_TIMEOUT;
      end
      out_entry.event_kind         = s4_ctl_ff.kind;
      out_entry.trigger            = s4_ctl_ff.trigger;
      out_entry.skipped            = s4_ctl_ff.skipped;
      out_entry.status             = last_status_in;
      out_entry.distance_hcm       = (last_status_in == STATUS_OK) ? last_dist_in : '0;
      out_entry.total_measurements = accepted_in;
      out_entry.total_errors       = rejected_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_status_ff <= STATUS_OK;
         last_dist_ff   <= '0;
         accepted_ff    <= '0;
         rejected_ff    <= '0;
      end else if (out_push) begin
         last_status_ff <= last_status_in;
         last_dist_ff   <= last_dist_in;
         accepted_ff    <= accepted_in;
         rejected_ff    <= rejected_in;
      end
   end
endmodule
